@@ rtl/hbpe_pkg.sv @@
// Shared types and constants for the Huffman bit packing encoder.
`timescale 1ns / 1ps
package hbpe_pkg;

  localparam int NUM_SYMBOLS  = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_CAP      = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int SYM_IDX_W    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_BYTE   = 2'd0,
    STATUS_END    = 2'd1,
    STATUS_NOCODE = 2'd2
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic        sym_ok;
    logic [7:0]  symbol;
    logic [5:0]  code_length;
    logic [31:0] code_bits;
  } q_item_t;

endpackage

@@ rtl/hbpe_front.sv @@
// Input stage: accepts words, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module hbpe_front import hbpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  symbol_i,
  input  logic [5:0]  code_length_i,
  input  logic [31:0] code_bits_i,
  output logic        q_valid_o,
  output q_item_t     q_item_o,
  input  logic        q_pop_i
);

  q_item_t             q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]  cnt_q;
  logic                full, push, pop;
  logic [5:0]          len_cap;
  logic [31:0]         bits_mask;
  q_item_t             item;

  assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign in_stall_o = full;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = q_mem[rd_ptr_q];
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    len_cap   = (code_length_i > 6'(LEN_CAP)) ? 6'(LEN_CAP) : code_length_i;
    bits_mask = (len_cap >= 6'd32) ? 32'hFFFF_FFFF : ~(32'hFFFF_FFFF << len_cap);
    item.kind        = kind_e'(kind_i);
    item.sym_ok      = ({1'b0, symbol_i} < 9'(NUM_SYMBOLS));
    item.symbol      = symbol_i;
    item.code_length = (item.kind == KIND_LOAD) ? len_cap : code_length_i;
    item.code_bits   = (item.kind == KIND_LOAD) ? (code_bits_i & bits_mask) : code_bits_i;
    push = in_valid_i && !full && (item.kind != KIND_NONE);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end
  end

endmodule

@@ rtl/hbpe_back.sv @@
// Engine: code table, bit packing and result output register.
`timescale 1ns / 1ps
module hbpe_back import hbpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] bit_total_o,
  output logic        last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT,
    S_FEND
  } state_e;

  state_e      state_q;
  logic [5:0]  len_mem  [NUM_SYMBOLS];
  logic [31:0] bits_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_q;

  q_item_t     item_q;
  logic [5:0]  rd_len_q;
  logic [31:0] rd_bits_q;
  logic        rd_vld_q;
  logic [6:0]  pend_q;
  logic [2:0]  pcnt_q;
  logic [31:0] total_q;
  logic        err_q;
  logic [38:0] acc_q;
  logic [5:0]  cnt_q;

  logic        out_vld_q;
  status_e     status_q;
  logic [7:0]  byte_q;
  logic [31:0] btot_q;
  logic        last_q;

  logic                 out_free, rd_en, wr_en;
  logic [SYM_IDX_W-1:0] rd_idx, wr_idx;
  logic [5:0]           clen;
  logic [38:0]          acc_next, byte_sh;
  logic [32:0]          sum;
  logic [7:0]           pad_byte;

  assign out_free = !out_vld_q || !out_stall_i;
  assign rd_en    = (state_q == S_IDLE) && q_valid_i;
  assign q_pop_o  = rd_en;
  assign rd_idx   = q_item_i.symbol[SYM_IDX_W-1:0];
  assign wr_idx   = item_q.symbol[SYM_IDX_W-1:0];
  assign wr_en    = (state_q == S_EXEC) && (item_q.kind == KIND_LOAD) && item_q.sym_ok;

  always_comb begin
    clen     = (item_q.sym_ok && rd_vld_q) ? rd_len_q : 6'd0;
    acc_next = ({32'b0, pend_q} << clen) | {7'b0, rd_bits_q};
    sum      = {1'b0, total_q} + {27'b0, clen};
    byte_sh  = acc_q >> (cnt_q - 6'd8);
    pad_byte = 8'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      len_mem[wr_idx]  <= item_q.code_length;
      bits_mem[wr_idx] <= item_q.code_bits;
    end
    if (rd_en) begin
      rd_len_q  <= len_mem[rd_idx];
      rd_bits_q <= bits_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      pend_q    <= '0;
      pcnt_q    <= '0;
      total_q   <= '0;
      err_q     <= 1'b0;
      acc_q     <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
      status_q  <= STATUS_BYTE;
      byte_q    <= '0;
      btot_q    <= '0;
      last_q    <= 1'b0;
    end else begin
      if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            item_q  <= q_item_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (item_q.kind)
            KIND_ENCODE: begin
              if (clen == 6'd0) begin
                if (out_free) begin
                  out_vld_q <= 1'b1;
                  status_q  <= STATUS_NOCODE;
                  byte_q    <= '0;
                  btot_q    <= '0;
                  last_q    <= 1'b1;
                  err_q     <= 1'b1;
                  state_q   <= S_IDLE;
                end
              end else begin
                acc_q   <= acc_next;
                cnt_q   <= {3'b0, pcnt_q} + clen;
                total_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                state_q <= S_EMIT;
              end
            end
            KIND_FLUSH: begin
              if (pcnt_q == 3'd0) begin
                state_q <= S_FEND;
              end else if (out_free) begin
                out_vld_q <= 1'b1;
                status_q  <= STATUS_BYTE;
                byte_q    <= pad_byte;
                btot_q    <= '0;
                last_q    <= 1'b0;
                state_q   <= S_FEND;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_EMIT: begin
          if (cnt_q >= 6'd8) begin
            if (out_free) begin
              out_vld_q <= 1'b1;
              status_q  <= STATUS_BYTE;
              byte_q    <= byte_sh[7:0];
              btot_q    <= '0;
              last_q    <= (cnt_q < 6'd16);
              cnt_q     <= cnt_q - 6'd8;
            end
          end else begin
            pend_q  <= acc_q[6:0] & ~(7'h7F << cnt_q[2:0]);
            pcnt_q  <= cnt_q[2:0];
            state_q <= S_IDLE;
          end
        end
        S_FEND: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            status_q  <= err_q ? STATUS_NOCODE : STATUS_END;
            byte_q    <= '0;
            btot_q    <= total_q;
            last_q    <= 1'b1;
            pend_q    <= '0;
            pcnt_q    <= '0;
            total_q   <= '0;
            err_q     <= 1'b0;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign out_byte_o  = byte_q;
  assign bit_total_o = btot_q;
  assign last_o      = last_q;

endmodule

@@ rtl/huffman_bit_packing_encoder.sv @@
// Flow: a queued word is taken by the idle engine and registered with its table entry; its
// first result is registered in the execute state (uncoded symbol, padded flush byte) or in
// the emit or flush-end state (encode, empty flush). The engine takes no new word until idle;
// its emit loop packs one byte per cycle unless stalled. A two-entry queue decouples input.
// Reset: asynchronous, active low; clears per-symbol valid bits at once (no clearing pass),
// empties the queue and the output register and clears the message state.
`timescale 1ns / 1ps
module huffman_bit_packing_encoder import hbpe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  symbol_i,
  input  logic [5:0]  code_length_i,
  input  logic [31:0] code_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_byte_o,
  output logic [31:0] bit_total_o,
  output logic        last_o
);

  logic    q_valid, q_pop;
  q_item_t q_item;

  hbpe_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .kind_i,
    .symbol_i,
    .code_length_i,
    .code_bits_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  hbpe_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .status_o,
    .out_byte_o,
    .bit_total_o,
    .last_o
  );

endmodule

@@ rtl/hbpe_checker.sv @@
// Port-level assertions for the Huffman bit packing encoder, bound to the top level.
`timescale 1ns / 1ps
module hbpe_checker import hbpe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  kind_i,
  input logic [7:0]  symbol_i,
  input logic [5:0]  code_length_i,
  input logic [31:0] code_bits_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  status_o,
  input logic [7:0]  out_byte_o,
  input logic [31:0] bit_total_o,
  input logic        last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_byte_o) && $stable(bit_total_o) && $stable(last_o))
    else $error("stalled result word changed");

  a_tail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_BYTE) |-> last_o && (out_byte_o == 8'd0))
    else $error("end or error word not last or has byte data");

  a_byte_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_BYTE) |-> (bit_total_o == 32'd0))
    else $error("byte word carries a bit total");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_BYTE) || (status_o == STATUS_END) ||
      (status_o == STATUS_NOCODE))
    else $error("undefined status on output");

endmodule

bind huffman_bit_packing_encoder hbpe_checker u_hbpe_checker (.*);
